>>> hdl/link_quality_score_defines.svh
// assertion helpers for the rtl
`ifndef LINK_QUALITY_SCORE_DEFINES_SVH
`define LINK_QUALITY_SCORE_DEFINES_SVH

// condition must never hold
`define LQS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define LQS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lqs_pkg.sv
`default_nettype none

package lqs_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int SNR_W       = 8;
    localparam int RATE_W      = 22;
    localparam int ERR_W       = 17;
    localparam int UTIL_W      = 7;
    localparam int SCORE_W     = 7;
    localparam int Q16_W       = 17;
    localparam int ROOT_W      = 16;
    localparam int RAD_W       = 32;
    localparam int REM_W       = 18;
    localparam int SQRT_STAGES = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_UTIL_BIAS  = 8'd0,
        CFG_UTIL_SLOPE = 8'd1
    } cfg_reg_t;

    localparam logic [Q16_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [19:0]      RATE_FULL  = 20'd866000;
    localparam logic [21:0]      RATE_FULL2 = 22'd1732000;
    localparam logic [35:0]      RATE_HALF  = 36'd433000;
    // floor(2^48 / 866000)
    localparam logic [28:0]      RATE_RECIP = 29'd325028841;
    localparam logic signed [24:0] ARG_LIMIT = 25'sd12800;
    // ceil(2^20 / 3)
    localparam logic [18:0]      RECIP3     = 19'd349526;
    localparam logic [8:0]       SCORE_MAX  = 9'd100;
    localparam logic [40:0]      ROUND_HALF = 41'h0080000000;
    localparam logic signed [SNR_W-1:0] SNR_FULL = 8'sd40;
    localparam logic [5:0]       SIG_KMAX   = 6'd12;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_acc_t;

    // round(snr * 65536 / 40) for snr in 1..39
    function automatic logic [Q16_W-1:0] snr_norm(input logic [5:0] s);
        logic [Q16_W-1:0] v;
        case (s)
            6'd1:  v = 17'd1638;
            6'd2:  v = 17'd3277;
            6'd3:  v = 17'd4915;
            6'd4:  v = 17'd6554;
            6'd5:  v = 17'd8192;
            6'd6:  v = 17'd9830;
            6'd7:  v = 17'd11469;
            6'd8:  v = 17'd13107;
            6'd9:  v = 17'd14746;
            6'd10: v = 17'd16384;
            6'd11: v = 17'd18022;
            6'd12: v = 17'd19661;
            6'd13: v = 17'd21299;
            6'd14: v = 17'd22938;
            6'd15: v = 17'd24576;
            6'd16: v = 17'd26214;
            6'd17: v = 17'd27853;
            6'd18: v = 17'd29491;
            6'd19: v = 17'd31130;
            6'd20: v = 17'd32768;
            6'd21: v = 17'd34406;
            6'd22: v = 17'd36045;
            6'd23: v = 17'd37683;
            6'd24: v = 17'd39322;
            6'd25: v = 17'd40960;
            6'd26: v = 17'd42598;
            6'd27: v = 17'd44237;
            6'd28: v = 17'd45875;
            6'd29: v = 17'd47514;
            6'd30: v = 17'd49152;
            6'd31: v = 17'd50790;
            6'd32: v = 17'd52429;
            6'd33: v = 17'd54067;
            6'd34: v = 17'd55706;
            6'd35: v = 17'd57344;
            6'd36: v = 17'd58982;
            6'd37: v = 17'd60621;
            6'd38: v = 17'd62259;
            6'd39: v = 17'd63898;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // round(65536 * sigmoid(k))
    function automatic logic [Q16_W-1:0] sig_point(input logic [3:0] k);
        logic [Q16_W-1:0] v;
        case (k)
            4'd0:  v = 17'd32768;
            4'd1:  v = 17'd47911;
            4'd2:  v = 17'd57724;
            4'd3:  v = 17'd62428;
            4'd4:  v = 17'd64357;
            4'd5:  v = 17'd65097;
            4'd6:  v = 17'd65374;
            4'd7:  v = 17'd65476;
            4'd8:  v = 17'd65514;
            4'd9:  v = 17'd65528;
            4'd10: v = 17'd65533;
            4'd11: v = 17'd65535;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lqs_if.sv
`default_nettype none

interface lqs_link_if;
    logic                           valid;
    logic                           ready;
    logic                           link_active;
    logic                           status_ok;
    logic signed [lqs_pkg::SNR_W-1:0] snr_db;
    logic [lqs_pkg::RATE_W-1:0]     rate_kbps;
    logic [lqs_pkg::ERR_W-1:0]      error_fraction;
    logic [lqs_pkg::UTIL_W-1:0]     util_pct;

    modport source (output valid, link_active, status_ok, snr_db, rate_kbps,
                    error_fraction, util_pct, input ready);
    modport sink (input valid, link_active, status_ok, snr_db, rate_kbps,
                  error_fraction, util_pct, output ready);
endinterface

interface lqs_score_if;
    logic                        valid;
    logic                        ready;
    logic [lqs_pkg::SCORE_W-1:0] score;

    modport source (output valid, score, input ready);
    modport sink (input valid, score, output ready);
endinterface

interface lqs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lqs_pkg::CFG_INDEX_W-1:0] index;
    logic [lqs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/lqs_isqrt.sv
`default_nettype none

// pipelined restoring square root, two result bits per stage
module lqs_isqrt #(
    parameter int SIDE_W = 18
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic [lqs_pkg::RAD_W-1:0]   radicand,
    input  wire logic [SIDE_W-1:0]           side_in,
    output logic                             out_vld,
    output logic [lqs_pkg::ROOT_W-1:0]       root,
    output logic [SIDE_W-1:0]                side_out
);

    localparam int NS = lqs_pkg::SQRT_STAGES;

    function automatic lqs_pkg::sqrt_acc_t sqrt_step(input lqs_pkg::sqrt_acc_t acc,
                                                     input logic [1:0] pair);
        logic [lqs_pkg::REM_W:0] rem_sh;
        logic [lqs_pkg::REM_W:0] trial;
        lqs_pkg::sqrt_acc_t      res;
        rem_sh = {acc.rem[lqs_pkg::REM_W-2:0], pair};
        trial  = {1'b0, acc.root, 2'b01};
        if (rem_sh >= trial)
        begin
            res.rem  = lqs_pkg::REM_W'(rem_sh - trial);
            res.root = {acc.root[lqs_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = rem_sh[lqs_pkg::REM_W-1:0];
            res.root = {acc.root[lqs_pkg::ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    lqs_pkg::sqrt_acc_t          acc_reg  [NS];
    logic [lqs_pkg::RAD_W-1:0]   rad_reg  [NS];
    logic [SIDE_W-1:0]           side_reg [NS];
    logic                        vld_reg  [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        lqs_pkg::sqrt_acc_t        acc_in;
        lqs_pkg::sqrt_acc_t        acc_mid;
        lqs_pkg::sqrt_acc_t        acc_next;
        logic [lqs_pkg::RAD_W-1:0] rad_in;
        logic [SIDE_W-1:0]         side_in_s;
        logic                      vld_in;

        if (s == 0)
        begin : g_first
            assign acc_in    = '0;
            assign rad_in    = radicand;
            assign side_in_s = side_in;
            assign vld_in    = in_vld;
        end
        else
        begin : g_rest
            assign acc_in    = acc_reg[s-1];
            assign rad_in    = rad_reg[s-1];
            assign side_in_s = side_reg[s-1];
            assign vld_in    = vld_reg[s-1];
        end

        always_comb
        begin
            acc_mid  = sqrt_step(acc_in, rad_in[lqs_pkg::RAD_W-1 -: 2]);
            acc_next = sqrt_step(acc_mid, rad_in[lqs_pkg::RAD_W-3 -: 2]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s]  <= acc_next;
                rad_reg[s]  <= {rad_in[lqs_pkg::RAD_W-5:0], 4'b0};
                side_reg[s] <= side_in_s;
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign root     = acc_reg[NS-1].root;
    assign side_out = side_reg[NS-1];

endmodule

`default_nettype wire

>>> hdl/link_quality_score.sv
`default_nettype none

// Link quality scorer: one link record in, one score 0..100 out. The pipeline takes a
// record every cycle unless the output stalls and returns its score in order; each
// record passes through five front stages (normalize, rate divide, rate correction
// and logistic weight, squares, mean), eight stages of the square root at two root
// bits each, two multiply stages and the output register. A stalled output holds
// the whole pipeline; input ready follows output ready whenever a result is waiting.
// Registers util_bias (index 0) and util_slope (index 1) must be written only while the block
// is idle (the block does not enforce this) and take effect for the next record; other indexes are ignored.
module link_quality_score (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lqs_link_if.sink    link_in,
    lqs_score_if.source score_out,
    lqs_cfg_if.sink     cfg
);

    `include "link_quality_score_defines.svh"

    logic en;

    logic signed [15:0] util_bias_reg;
    logic signed [15:0] util_slope_reg;

    // stage 1
    logic        s1_vld_reg;
    logic        s1_ok_reg, s1_ok_next;
    logic [16:0] s1_nsnr_reg, s1_nsnr_next;
    logic [16:0] s1_nerr_reg, s1_nerr_next;
    logic [19:0] s1_rate_reg, s1_rate_next;
    logic [48:0] s1_rprod_reg, s1_rprod_next;
    logic signed [24:0] s1_arg_reg, s1_arg_next;
    logic signed [24:0] bias_x, slope_x, util_x, slope_prod;

    // stage 2
    logic        s2_vld_reg;
    logic        s2_ok_reg;
    logic [16:0] s2_nsnr_reg, s2_nerr_reg;
    logic [16:0] s2_q_reg, s2_q_next;
    logic [21:0] s2_r_reg, s2_r_next;
    logic [13:0] s2_aabs_reg, s2_aabs_next;
    logic        s2_neg_reg, s2_neg_next;
    logic [35:0] rate_num;
    logic [36:0] rate_qm;
    logic [36:0] rate_diff;

    // stage 3
    logic        s3_vld_reg;
    logic        s3_ok_reg;
    logic [16:0] s3_nsnr_reg, s3_nerr_reg;
    logic [16:0] s3_nrate_reg, s3_nrate_next;
    logic [16:0] s3_weight_reg, s3_weight_next;
    logic [5:0]  sig_k;
    logic [16:0] sig_t0, sig_t1, sig_diff, sig_pos;
    logic [24:0] sig_ip;

    // stage 4
    logic        s4_vld_reg;
    logic        s4_ok_reg;
    logic [16:0] s4_weight_reg;
    logic [16:0] s4_sq_snr_reg, s4_sq_rate_reg, s4_sq_err_reg;
    logic [16:0] sq_snr_next, sq_rate_next, sq_err_next;
    logic [33:0] sq_snr_full, sq_rate_full, sq_err_full;

    // stage 5
    logic        s5_vld_reg;
    logic        s5_ok_reg;
    logic [16:0] s5_weight_reg;
    logic [36:0] s5_prod_reg, s5_prod_next;
    logic signed [18:0] sq_sum;
    logic [17:0] sq_pos;

    // square root
    logic        sq_vld;
    logic [15:0] sq_root;
    logic [17:0] sq_side;

    // final multiplies
    logic        f1_vld_reg;
    logic        f1_ok_reg;
    logic [16:0] f1_weight_reg;
    logic [22:0] f1_r100_reg;
    logic        f2_vld_reg;
    logic        f2_ok_reg;
    logic [39:0] f2_prod_reg;

    logic        out_vld_reg;
    logic [6:0]  out_score_reg, out_score_next;
    logic [40:0] round_sum;
    logic [8:0]  score_raw;

    assign en             = !out_vld_reg || score_out.ready;
    assign link_in.ready  = en;
    assign cfg.ready      = 1'b1;
    assign score_out.valid = out_vld_reg;
    assign score_out.score = out_score_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            util_bias_reg  <= '0;
            util_slope_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (lqs_pkg::cfg_reg_t'(cfg.index))
                lqs_pkg::CFG_UTIL_BIAS:  util_bias_reg  <= cfg.data;
                lqs_pkg::CFG_UTIL_SLOPE: util_slope_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // stage 1: normalize and start rate divide
    always_comb
    begin
        s1_ok_next = link_in.link_active & link_in.status_ok;
        if (link_in.snr_db <= 8'sd0)
        begin
            s1_nsnr_next = '0;
        end
        else if (link_in.snr_db >= lqs_pkg::SNR_FULL)
        begin
            s1_nsnr_next = lqs_pkg::ONE_Q16;
        end
        else
        begin
            s1_nsnr_next = lqs_pkg::snr_norm(link_in.snr_db[5:0]);
        end
        s1_rate_next = (link_in.rate_kbps > 22'(lqs_pkg::RATE_FULL)) ?
                       lqs_pkg::RATE_FULL : link_in.rate_kbps[19:0];
        s1_rprod_next = 49'(s1_rate_next) * 49'(lqs_pkg::RATE_RECIP);
        s1_nerr_next = (link_in.error_fraction > lqs_pkg::ONE_Q16) ?
                       lqs_pkg::ONE_Q16 : link_in.error_fraction;
        bias_x     = {{9{util_bias_reg[15]}}, util_bias_reg};
        slope_x    = {{9{util_slope_reg[15]}}, util_slope_reg};
        util_x     = {18'b0, link_in.util_pct};
        slope_prod = slope_x * util_x;
        s1_arg_next = bias_x + slope_prod;
    end

    // stage 2: rate remainder, clamp logistic argument
    always_comb
    begin
        s2_q_next = s1_rprod_reg[48:32];
        rate_num  = {s1_rate_reg, 16'b0} + lqs_pkg::RATE_HALF;
        rate_qm   = 37'(s2_q_next) * 37'(lqs_pkg::RATE_FULL);
        rate_diff = 37'(rate_num) - rate_qm;
        s2_r_next = rate_diff[21:0];
        if (s1_arg_reg > lqs_pkg::ARG_LIMIT)
        begin
            s2_aabs_next = 14'(lqs_pkg::ARG_LIMIT);
            s2_neg_next  = 1'b0;
        end
        else if (s1_arg_reg < -lqs_pkg::ARG_LIMIT)
        begin
            s2_aabs_next = 14'(lqs_pkg::ARG_LIMIT);
            s2_neg_next  = 1'b1;
        end
        else if (s1_arg_reg < 25'sd0)
        begin
            s2_aabs_next = 14'(-s1_arg_reg);
            s2_neg_next  = 1'b1;
        end
        else
        begin
            s2_aabs_next = s1_arg_reg[13:0];
            s2_neg_next  = 1'b0;
        end
    end

    // stage 3: rate quotient correction, sigmoid interpolation
    always_comb
    begin
        if (s2_r_reg >= lqs_pkg::RATE_FULL2)
        begin
            s3_nrate_next = s2_q_reg + 17'd2;
        end
        else if (s2_r_reg >= 22'(lqs_pkg::RATE_FULL))
        begin
            s3_nrate_next = s2_q_reg + 17'd1;
        end
        else
        begin
            s3_nrate_next = s2_q_reg;
        end
        sig_k    = s2_aabs_reg[13:8];
        sig_t0   = lqs_pkg::sig_point(sig_k[3:0]);
        sig_t1   = lqs_pkg::sig_point(sig_k[3:0] + 4'd1);
        sig_diff = sig_t1 - sig_t0;
        sig_ip   = 25'(sig_diff) * 25'(s2_aabs_reg[7:0]) + 25'd128;
        if (sig_k >= lqs_pkg::SIG_KMAX)
        begin
            sig_pos = lqs_pkg::ONE_Q16;
        end
        else
        begin
            sig_pos = sig_t0 + 17'(sig_ip >> 8);
        end
        s3_weight_next = s2_neg_reg ? (lqs_pkg::ONE_Q16 - sig_pos) : sig_pos;
    end

    // stage 4: rounded squares
    always_comb
    begin
        sq_snr_full  = 34'(s3_nsnr_reg) * 34'(s3_nsnr_reg) + 34'd32768;
        sq_rate_full = 34'(s3_nrate_reg) * 34'(s3_nrate_reg) + 34'd32768;
        sq_err_full  = 34'(s3_nerr_reg) * 34'(s3_nerr_reg) + 34'd32768;
        sq_snr_next  = sq_snr_full[32:16];
        sq_rate_next = sq_rate_full[32:16];
        sq_err_next  = sq_err_full[32:16];
    end

    // stage 5: signed sum, clamp at zero, divide by three
    always_comb
    begin
        sq_sum = $signed({2'b0, s4_sq_snr_reg}) + $signed({2'b0, s4_sq_rate_reg})
               - $signed({2'b0, s4_sq_err_reg});
        sq_pos = (sq_sum <= 19'sd0) ? 18'd0 : sq_sum[17:0];
        s5_prod_next = 37'(sq_pos) * 37'(lqs_pkg::RECIP3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= link_in.valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            f1_vld_reg  <= sq_vld;
            f2_vld_reg  <= f1_vld_reg;
            out_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ok_reg      <= s1_ok_next;
            s1_nsnr_reg    <= s1_nsnr_next;
            s1_nerr_reg    <= s1_nerr_next;
            s1_rate_reg    <= s1_rate_next;
            s1_rprod_reg   <= s1_rprod_next;
            s1_arg_reg     <= s1_arg_next;

            s2_ok_reg      <= s1_ok_reg;
            s2_nsnr_reg    <= s1_nsnr_reg;
            s2_nerr_reg    <= s1_nerr_reg;
            s2_q_reg       <= s2_q_next;
            s2_r_reg       <= s2_r_next;
            s2_aabs_reg    <= s2_aabs_next;
            s2_neg_reg     <= s2_neg_next;

            s3_ok_reg      <= s2_ok_reg;
            s3_nsnr_reg    <= s2_nsnr_reg;
            s3_nerr_reg    <= s2_nerr_reg;
            s3_nrate_reg   <= s3_nrate_next;
            s3_weight_reg  <= s3_weight_next;

            s4_ok_reg      <= s3_ok_reg;
            s4_weight_reg  <= s3_weight_reg;
            s4_sq_snr_reg  <= sq_snr_next;
            s4_sq_rate_reg <= sq_rate_next;
            s4_sq_err_reg  <= sq_err_next;

            s5_ok_reg      <= s4_ok_reg;
            s5_weight_reg  <= s4_weight_reg;
            s5_prod_reg    <= s5_prod_next;

            f1_ok_reg      <= sq_side[17];
            f1_weight_reg  <= sq_side[16:0];
            f1_r100_reg    <= 23'(sq_root) * 23'(lqs_pkg::SCORE_MAX);

            f2_ok_reg      <= f1_ok_reg;
            f2_prod_reg    <= 40'(f1_r100_reg) * 40'(f1_weight_reg);

            out_score_reg  <= out_score_next;
        end
    end

    // mean is below 2^16, so mean << 16 fits the radicand
    lqs_isqrt #(
        .SIDE_W (18)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s5_vld_reg),
        .radicand ({s5_prod_reg[35:20], 16'b0}),
        .side_in  ({s5_ok_reg, s5_weight_reg}),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .side_out (sq_side)
    );

    // round half up and clamp; score is zero when the link is not active or status is not ok
    always_comb
    begin
        round_sum = 41'(f2_prod_reg) + lqs_pkg::ROUND_HALF;
        score_raw = round_sum[40:32];
        if (!f2_ok_reg)
        begin
            out_score_next = '0;
        end
        else if (score_raw > lqs_pkg::SCORE_MAX)
        begin
            out_score_next = 7'(lqs_pkg::SCORE_MAX);
        end
        else
        begin
            out_score_next = score_raw[6:0];
        end
    end

    `LQS_ASSERT_NEVER(a_score_range, out_vld_reg && (out_score_reg > 7'(lqs_pkg::SCORE_MAX)), "score above 100")
    `LQS_ASSERT_NEXT(a_accept_enters, link_in.valid && link_in.ready, s1_vld_reg, "accepted beat not in stage 1")
    `LQS_ASSERT_NEXT(a_stall_holds, !en, $stable({s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, f1_vld_reg, f2_vld_reg}), "pipeline moved during stall")
    `LQS_ASSERT_IMPL(a_ready_when_empty, !out_vld_reg, link_in.ready, "input blocked with empty output")

endmodule

`default_nettype wire
